/* hdl/iff_pkg.sv */
package iff_pkg;

	// Widths of the item fields.
	localparam int VALUE_W = 64;
	localparam int KIND_W = 3;
	localparam int CNT_W = 7;
	localparam int CH_W = 8;
	localparam int DIG_W = 4;

	// Defaults of the top-level parameters.
	localparam int VALUE_BITS_DEF = 64;
	localparam int MAX_CHARS_DEF = 64;

	// Conversion kinds. Codes above the upper hex kind format as unsigned decimal.
	localparam logic [KIND_W-1:0] KIND_SDEC = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UDEC = 3'd1;
	localparam logic [KIND_W-1:0] KIND_OCT = 3'd2;
	localparam logic [KIND_W-1:0] KIND_HEXL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_HEXU = 3'd4;

	// ASCII characters used in the layout.
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_PLUS = 8'h2B;
	localparam logic [CH_W-1:0] CH_BLANK = 8'h20;
	localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CH_W-1:0] CH_X_LOW = 8'h78;
	localparam logic [CH_W-1:0] CH_X_UP = 8'h58;
	localparam logic [CH_W-1:0] CH_A_LOW = 8'h61;
	localparam logic [CH_W-1:0] CH_A_UP = 8'h41;

	// Layout of one formatted number, handed from the front to the back.
	typedef struct packed {
		logic [CNT_W-1:0] lead;
		logic sign_on;
		logic [CH_W-1:0] sign_ch;
		logic pfx_zero;
		logic pfx_x;
		logic upper;
		logic [CNT_W-1:0] zeros;
		logic [CNT_W-1:0] ndig;
		logic [CNT_W-1:0] trail;
	} job_t;

	// Digit symbol, as in "0123456789abcdef" or "0123456789ABCDEF".
	function automatic logic [CH_W-1:0] digit_char(input logic [DIG_W-1:0] d,
			input logic upper);
		logic [CH_W-1:0] ext;
		ext = CH_W'(d);
		if (d < 4'd10) begin
			return CH_ZERO + ext;
		end
		return (upper ? CH_A_UP : CH_A_LOW) + ext - CH_W'(10);
	endfunction

endpackage

/* hdl/iff_ifs.sv */
// Number channel: one integer with its conversion flags per item.
interface iff_num_if;
	logic valid;
	logic ready;
	logic signed [iff_pkg::VALUE_W-1:0] value;
	logic [iff_pkg::KIND_W-1:0] kind;
	logic left_justify;
	logic force_sign;
	logic blank_sign;
	logic alt_form;
	logic zero_pad;
	logic [iff_pkg::CNT_W-1:0] field_width;
	logic signed [iff_pkg::CNT_W-1:0] min_digits;

	modport source (output valid, value, kind, left_justify, force_sign, blank_sign,
		alt_form, zero_pad, field_width, min_digits, input ready);
	modport sink (input valid, value, kind, left_justify, force_sign, blank_sign,
		alt_form, zero_pad, field_width, min_digits, output ready);
endinterface

// Text channel: one character per item.
interface iff_text_if;
	logic valid;
	logic ready;
	logic [iff_pkg::CH_W-1:0] ch;
	logic last;

	modport source (output valid, ch, last, input ready);
	modport sink (input valid, ch, last, output ready);
endinterface

/* hdl/iff_front.sv */
module iff_front #(
	parameter int VALUE_BITS = iff_pkg::VALUE_BITS_DEF,
	parameter int MAX_CHARS = iff_pkg::MAX_CHARS_DEF
) (
	input logic clk,
	input logic arst_n,
	iff_num_if.sink num,
	output iff_pkg::job_t job,
	output logic [iff_pkg::DIG_W*((VALUE_BITS+2)/3)-1:0] job_dig,
	output logic job_valid,
	input logic job_ready
);
	import iff_pkg::*;

	localparam int DIG_N = (VALUE_BITS + 2) / 3;
	localparam int BCD_W = DIG_W * DIG_N;
	localparam int OCT_W = 3 * DIG_N;
	localparam int BIN_W = 2 * ((VALUE_BITS + 1) / 2);
	localparam int STEPS = BIN_W / 2;
	localparam int STEP_W = $clog2(STEPS + 1);

	typedef enum logic [1:0] {BASE_DEC, BASE_OCT, BASE_HEX} base_t;
	typedef enum logic [1:0] {S_IDLE, S_CONV, S_LEN, S_PUSH} state_t;

	state_t state_q;
	base_t base_q;
	logic upper_q, neg_q, left_q, plus_q, blank_q, alt_q, zpad_q;
	logic [CNT_W-1:0] fw_q, prec_q, ndig_q, npre_q;
	logic [BCD_W-1:0] dig_q;
	logic [BIN_W-1:0] bin_q;
	logic [STEP_W-1:0] step_q;

	// One shift-and-add-three step of the binary to BCD conversion.
	function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] b,
			input logic bit_in);
		logic [BCD_W-1:0] adj;
		for (int i = 0; i < DIG_N; i++) begin
			adj[DIG_W*i +: DIG_W] = (b[DIG_W*i +: DIG_W] >= 4'd5) ?
				b[DIG_W*i +: DIG_W] + 4'd3 : b[DIG_W*i +: DIG_W];
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

	// Classify the incoming number and take its magnitude.
	logic [VALUE_BITS-1:0] raw, mag;
	logic neg_in;
	base_t base_in;
	logic [OCT_W-1:0] mag_oct;
	logic [BCD_W-1:0] mag_hex;
	logic [BCD_W-1:0] dig_in;

	assign raw = num.value[VALUE_BITS-1:0];
	assign neg_in = (num.kind == KIND_SDEC) && raw[VALUE_BITS-1];
	assign mag = neg_in ? (~raw) + {{(VALUE_BITS-1){1'b0}}, 1'b1} : raw;
	assign mag_oct = OCT_W'(mag);
	assign mag_hex = BCD_W'(mag);

	always_comb begin
		case (num.kind)
			KIND_SDEC, KIND_UDEC: base_in = BASE_DEC;
			KIND_OCT: base_in = BASE_OCT;
			KIND_HEXL, KIND_HEXU: base_in = BASE_HEX;
			default: base_in = BASE_DEC;
		endcase
	end

	// Octal and hex digits are plain slices of the magnitude.
	always_comb begin
		for (int i = 0; i < DIG_N; i++) begin
			case (base_in)
				BASE_OCT: dig_in[DIG_W*i +: DIG_W] = {1'b0, mag_oct[3*i +: 3]};
				BASE_HEX: dig_in[DIG_W*i +: DIG_W] = mag_hex[DIG_W*i +: DIG_W];
				default: dig_in[DIG_W*i +: DIG_W] = '0;
			endcase
		end
	end

	// Digit count: position of the highest non-zero digit, at least one.
	logic [CNT_W-1:0] ndig_c;
	always_comb begin
		ndig_c = CNT_W'(1);
		for (int i = 0; i < DIG_N; i++) begin
			if (dig_q[DIG_W*i +: DIG_W] != '0) begin
				ndig_c = CNT_W'(i + 1);
			end
		end
	end

	// Sign and prefix lengths, and the precision limited to the field maximum.
	logic sign_on, pfx_zero, pfx_x;
	logic [CNT_W-1:0] npre_c, lim_c, prec_c;
	assign sign_on = neg_q | plus_q | blank_q;
	assign pfx_zero = alt_q && (base_q != BASE_DEC);
	assign pfx_x = alt_q && (base_q == BASE_HEX);
	assign npre_c = CNT_W'(sign_on) + CNT_W'(pfx_zero) + CNT_W'(pfx_x);
	assign lim_c = CNT_W'(MAX_CHARS) - npre_c;
	assign prec_c = (prec_q > lim_c) ? lim_c : prec_q;

	// Zeros and padding of the final layout.
	logic [CNT_W-1:0] nz0, body, pad;
	logic zfill;
	assign nz0 = (prec_q > ndig_q) ? prec_q - ndig_q : '0;
	assign body = npre_q + nz0 + ndig_q;
	assign pad = (fw_q > body) ? fw_q - body : '0;
	assign zfill = zpad_q && !left_q;

	always_comb begin
		job.lead = (!zfill && !left_q) ? pad : '0;
		job.sign_on = sign_on;
		job.sign_ch = neg_q ? CH_MINUS : (plus_q ? CH_PLUS : CH_BLANK);
		job.pfx_zero = pfx_zero;
		job.pfx_x = pfx_x;
		job.upper = upper_q;
		job.zeros = nz0 + (zfill ? pad : '0);
		job.ndig = ndig_q;
		job.trail = left_q ? pad : '0;
	end

	assign job_dig = dig_q;
	assign job_valid = (state_q == S_PUSH);
	assign num.ready = (state_q == S_IDLE);

	// Sequencer: capture, decimal conversion two bits a cycle, layout, hand-over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			base_q <= BASE_DEC;
			upper_q <= 1'b0;
			neg_q <= 1'b0;
			left_q <= 1'b0;
			plus_q <= 1'b0;
			blank_q <= 1'b0;
			alt_q <= 1'b0;
			zpad_q <= 1'b0;
			fw_q <= '0;
			prec_q <= '0;
			ndig_q <= '0;
			npre_q <= '0;
			dig_q <= '0;
			bin_q <= '0;
			step_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (num.valid) begin
						base_q <= base_in;
						upper_q <= (num.kind == KIND_HEXU);
						neg_q <= neg_in;
						left_q <= num.left_justify;
						plus_q <= num.force_sign;
						blank_q <= num.blank_sign;
						alt_q <= num.alt_form;
						zpad_q <= num.zero_pad;
						fw_q <= (num.field_width > CNT_W'(MAX_CHARS)) ?
							CNT_W'(MAX_CHARS) : num.field_width;
						prec_q <= num.min_digits[CNT_W-1] ? '0 : $unsigned(num.min_digits);
						dig_q <= dig_in;
						bin_q <= BIN_W'(mag);
						step_q <= STEP_W'(STEPS);
						state_q <= (base_in == BASE_DEC) ? S_CONV : S_LEN;
					end
				end
				S_CONV: begin
					dig_q <= dabble(dabble(dig_q, bin_q[BIN_W-1]), bin_q[BIN_W-2]);
					bin_q <= {bin_q[BIN_W-3:0], 2'b00};
					step_q <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) begin
						state_q <= S_LEN;
					end
				end
				S_LEN: begin
					ndig_q <= ndig_c;
					npre_q <= npre_c;
					prec_q <= prec_c;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (job_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hdl/iff_queue.sv */
module iff_queue #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic [W-1:0] in_data,
	input logic in_valid,
	output logic in_ready,
	output logic [W-1:0] out_data,
	output logic out_valid,
	input logic out_ready
);
	localparam int QD = 2;
	localparam int PTR_W = $clog2(QD);

	logic [W-1:0] mem_q [QD];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != (PTR_W+1)'(QD));
	assign out_valid = (cnt_q != '0);
	assign out_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + PTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

/* hdl/iff_back.sv */
module iff_back #(
	parameter int VALUE_BITS = iff_pkg::VALUE_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input iff_pkg::job_t job,
	input logic [iff_pkg::DIG_W*((VALUE_BITS+2)/3)-1:0] job_dig,
	input logic job_valid,
	output logic job_ready,
	iff_text_if.source text
);
	import iff_pkg::*;

	localparam int DIG_N = (VALUE_BITS + 2) / 3;
	localparam int IDX_W = $clog2(DIG_N);

	logic active_q;
	logic [CNT_W-1:0] pos_q, last_q;
	logic [CNT_W-1:0] e_lead_q, e_sign_q, e_pz_q, e_px_q, e_zero_q, e_dig_q;
	logic [CH_W-1:0] sign_ch_q;
	logic upper_q;
	logic [DIG_W-1:0] dig_q [DIG_N];
	logic ovalid_q, olast_q;
	logic [CH_W-1:0] och_q;

	// Section ends of the text, counted in characters from the start.
	logic [CNT_W-1:0] e_lead, e_sign, e_pz, e_px, e_zero, e_dig, e_all;
	assign e_lead = job.lead;
	assign e_sign = e_lead + CNT_W'(job.sign_on);
	assign e_pz = e_sign + CNT_W'(job.pfx_zero);
	assign e_px = e_pz + CNT_W'(job.pfx_x);
	assign e_zero = e_px + job.zeros;
	assign e_dig = e_zero + job.ndig;
	assign e_all = e_dig + job.trail;

	// Character at the current position.
	logic [CNT_W-1:0] didx;
	logic [CH_W-1:0] ch_c;
	assign didx = e_dig_q - CNT_W'(1) - pos_q;
	always_comb begin
		if (pos_q < e_lead_q) begin
			ch_c = CH_BLANK;
		end else if (pos_q < e_sign_q) begin
			ch_c = sign_ch_q;
		end else if (pos_q < e_pz_q) begin
			ch_c = CH_ZERO;
		end else if (pos_q < e_px_q) begin
			ch_c = upper_q ? CH_X_UP : CH_X_LOW;
		end else if (pos_q < e_zero_q) begin
			ch_c = CH_ZERO;
		end else if (pos_q < e_dig_q) begin
			ch_c = digit_char(dig_q[didx[IDX_W-1:0]], upper_q);
		end else begin
			ch_c = CH_BLANK;
		end
	end

	logic adv;
	assign adv = active_q && (!ovalid_q || text.ready);
	assign job_ready = !active_q;

	assign text.valid = ovalid_q;
	assign text.ch = och_q;
	assign text.last = olast_q;

	// Take a layout, then send one character a cycle through the output register while the text channel accepts them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q <= '0;
			last_q <= '0;
			e_lead_q <= '0;
			e_sign_q <= '0;
			e_pz_q <= '0;
			e_px_q <= '0;
			e_zero_q <= '0;
			e_dig_q <= '0;
			sign_ch_q <= '0;
			upper_q <= 1'b0;
			for (int i = 0; i < DIG_N; i++) begin
				dig_q[i] <= '0;
			end
			ovalid_q <= 1'b0;
			olast_q <= 1'b0;
			och_q <= '0;
		end else begin
			if (!active_q && job_valid) begin
				active_q <= 1'b1;
				pos_q <= '0;
				last_q <= e_all - CNT_W'(1);
				e_lead_q <= e_lead;
				e_sign_q <= e_sign;
				e_pz_q <= e_pz;
				e_px_q <= e_px;
				e_zero_q <= e_zero;
				e_dig_q <= e_dig;
				sign_ch_q <= job.sign_ch;
				upper_q <= job.upper;
				for (int i = 0; i < DIG_N; i++) begin
					dig_q[i] <= job_dig[DIG_W*i +: DIG_W];
				end
			end
			if (adv) begin
				ovalid_q <= 1'b1;
				och_q <= ch_c;
				olast_q <= (pos_q == last_q);
				pos_q <= pos_q + CNT_W'(1);
				if (pos_q == last_q) begin
					active_q <= 1'b0;
				end
			end else if (text.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

endmodule

/* hdl/integer_field_formatter_unit.sv */
// Integer field formatter: turns one number with a printf-style integer conversion
// (signed or unsigned decimal, octal, lower or upper hex, with the left, plus, space,
// alternate and zero flags, a field width and a precision) into its text, one ASCII
// character per item on the text channel, the final character marked by last.
// A front stage takes the number, converts it and works out the layout; a two-entry
// queue hands the layout to a back stage that sends the characters through an output
// register, so the front converts the next number while the back is still sending.
// Decimal conversion runs a binary to BCD shifter at two bits a cycle; octal and hex
// need none. The front takes the number, converts it if it is decimal, registers the
// layout and hands it over, and takes no new number until that hand-over is done.
// The back takes each layout and then sends one character a cycle while the text
// channel accepts them, and takes the next layout only once it has registered the
// last character of the one before.
// There is no clearing pass after reset.
module integer_field_formatter_unit #(
	parameter int VALUE_BITS = iff_pkg::VALUE_BITS_DEF,
	parameter int MAX_CHARS = iff_pkg::MAX_CHARS_DEF
) (
	input logic clk,
	input logic arst_n,
	iff_num_if.sink num,
	iff_text_if.source text
);
	import iff_pkg::*;

	localparam int DIG_N = (VALUE_BITS + 2) / 3;
	localparam int BCD_W = DIG_W * DIG_N;
	localparam int JOB_W = $bits(job_t) + BCD_W;

	job_t f_job, b_job;
	logic [BCD_W-1:0] f_dig, b_dig;
	logic f_valid, f_ready, b_valid, b_ready;

	iff_front #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_CHARS(MAX_CHARS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.num(num),
		.job(f_job),
		.job_dig(f_dig),
		.job_valid(f_valid),
		.job_ready(f_ready)
	);

	// Layout queue between conversion and character output.
	iff_queue #(
		.W(JOB_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.in_data({f_job, f_dig}),
		.in_valid(f_valid),
		.in_ready(f_ready),
		.out_data({b_job, b_dig}),
		.out_valid(b_valid),
		.out_ready(b_ready)
	);

	iff_back #(
		.VALUE_BITS(VALUE_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.job(b_job),
		.job_dig(b_dig),
		.job_valid(b_valid),
		.job_ready(b_ready),
		.text(text)
	);

endmodule
